FILE: sv/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

    // One stored entry: fifteen characters, character 0 in the low byte.
    localparam int unsigned ENTRY_W = 120;
    localparam int unsigned LOW_W   = 64;
    localparam int unsigned HIGH_W  = 56;

    typedef logic [ENTRY_W-1:0] entry_t;

    // Request codes.
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_REAR   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_REAR,
        CELL_POP_FRONT,
        CELL_ROTATE
    } cell_op_t;

    // Position flags of one cell relative to the current fill.
    typedef struct packed {
        logic tail;     // cell holds the rear entry
        logic at_count; // first free cell, target of a rear push
    } cell_flags_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

`default_nettype wire

FILE: sv/bsd_cell.sv
`default_nettype none

module bsd_cell (
    input  wire                  aclk,
    input  bsd_pkg::cell_op_t    op,
    input  bsd_pkg::cell_flags_t flags,
    input  bsd_pkg::entry_t      left_data,
    input  bsd_pkg::entry_t      right_data,
    input  bsd_pkg::entry_t      head_data,
    input  bsd_pkg::entry_t      push_data,
    output bsd_pkg::entry_t      data
);

    bsd_pkg::entry_t data_reg;
    bsd_pkg::entry_t data_next;

    // Each cell takes its own value, a neighbour's, the head or the pushed entry.
    always_comb begin
        data_next = data_reg;
        case (op)
            bsd_pkg::CELL_PUSH_FRONT: data_next = left_data;
            bsd_pkg::CELL_PUSH_REAR: begin
                if (flags.at_count) begin
                    data_next = push_data;
                end
            end
            bsd_pkg::CELL_POP_FRONT: data_next = right_data;
            bsd_pkg::CELL_ROTATE: begin
                data_next = flags.tail ? head_data : right_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: sv/bounded_string_deque_unit.sv
`default_nettype none

// Bounded double-ended queue of DEPTH fifteen-character entries, kept in
// order from front to rear in a chain of cells that shift together. Each
// push and pop request gives one result transfer. A list request gives
// one transfer per stored entry, one per cycle while the output register
// is free, by reading the front cell while the chain rotates by one place;
// after entry_count rotations the order is restored. A new request is
// taken once the last result of the previous one sits in the output
// register and that register is free, so the input waits until a list has
// been sent and while results stall. A push onto a full queue is refused
// with status full; pops and lists of an empty queue return status empty.
module bounded_string_deque_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  [2:0]              s_req_type,
    input  wire  [bsd_pkg::LOW_W-1:0]  s_text_low,
    input  wire  [bsd_pkg::HIGH_W-1:0] s_text_high,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [1:0]              m_status,
    output logic                    m_has_entry,
    output logic [bsd_pkg::LOW_W-1:0]  m_entry_low,
    output logic [bsd_pkg::HIGH_W-1:0] m_entry_high,
    output logic                    m_last
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bsd_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    bsd_pkg::cell_op_t cell_op;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic              m_has_entry_reg, m_has_entry_next;
    bsd_pkg::entry_t   m_entry_reg, m_entry_next;
    logic              m_last_reg, m_last_next;

    bsd_pkg::entry_t   push_data;
    bsd_pkg::entry_t   cell_data [DEPTH];
    bsd_pkg::entry_t   tail_data;
    bsd_pkg::cell_flags_t cell_flags [DEPTH];
    logic              out_free;
    logic              accept;

    assign push_data = {s_text_high, s_text_low};
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == bsd_pkg::ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;

    // The chain of cells, front entry in cell 0.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bsd_pkg::entry_t left_data;
        bsd_pkg::entry_t right_data;

        if (i == 0) begin : g_first
            assign left_data = push_data;
        end else begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        assign cell_flags[i].tail     = (count_reg == CNT_W'(i + 1));
        assign cell_flags[i].at_count = (count_reg == CNT_W'(i));

        bsd_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .flags      (cell_flags[i]),
            .left_data  (left_data),
            .right_data (right_data),
            .head_data  (cell_data[0]),
            .push_data  (push_data),
            .data       (cell_data[i])
        );
    end

    // Rear entry selected by the tail flags.
    always_comb begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_flags[i].tail) begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    // Request decode, list sequencing and output register loading.
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        cell_op          = bsd_pkg::CELL_HOLD;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_has_entry_next = m_has_entry_reg;
        m_entry_next     = m_entry_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            bsd_pkg::ST_IDLE: begin
                if (accept) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = bsd_pkg::ST_OK;
                    m_has_entry_next = 1'b0;
                    m_entry_next     = '0;
                    m_last_next      = 1'b1;
                    case (s_req_type)
                        bsd_pkg::REQ_PUSH_FRONT, bsd_pkg::REQ_PUSH_REAR: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                m_status_next = bsd_pkg::ST_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                cell_op    = (s_req_type == bsd_pkg::REQ_PUSH_FRONT) ?
                                             bsd_pkg::CELL_PUSH_FRONT :
                                             bsd_pkg::CELL_PUSH_REAR;
                            end
                        end
                        bsd_pkg::REQ_POP_FRONT, bsd_pkg::REQ_POP_REAR: begin
                            if (count_reg == '0) begin
                                m_status_next = bsd_pkg::ST_EMPTY;
                            end else begin
                                count_next       = count_reg - CNT_W'(1);
                                m_has_entry_next = 1'b1;
                                if (s_req_type == bsd_pkg::REQ_POP_FRONT) begin
                                    m_entry_next = cell_data[0];
                                    cell_op      = bsd_pkg::CELL_POP_FRONT;
                                end else begin
                                    m_entry_next = tail_data;
                                end
                            end
                        end
                        bsd_pkg::REQ_LIST: begin
                            if (count_reg == '0) begin
                                m_status_next = bsd_pkg::ST_EMPTY;
                            end else begin
                                m_has_entry_next = 1'b1;
                                m_entry_next     = cell_data[0];
                                cell_op          = bsd_pkg::CELL_ROTATE;
                                remain_next      = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1)) begin
                                    m_last_next = 1'b0;
                                    state_next  = bsd_pkg::ST_LIST;
                                end
                            end
                        end
                        default: m_status_next = bsd_pkg::ST_INVALID;
                    endcase
                end
            end
            bsd_pkg::ST_LIST: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = bsd_pkg::ST_OK;
                    m_has_entry_next = 1'b1;
                    m_entry_next     = cell_data[0];
                    m_last_next      = (remain_reg == CNT_W'(1));
                    cell_op          = bsd_pkg::CELL_ROTATE;
                    remain_next      = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = bsd_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = bsd_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsd_pkg::ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        m_status_reg    <= m_status_next;
        m_has_entry_reg <= m_has_entry_next;
        m_entry_reg     <= m_entry_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_has_entry  = m_has_entry_reg;
    assign m_entry_low  = m_entry_reg[bsd_pkg::LOW_W-1:0];
    assign m_entry_high = m_entry_reg[bsd_pkg::ENTRY_W-1:bsd_pkg::LOW_W];
    assign m_last       = m_last_reg;

    // The fill never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // While listing, entries remain to be sent and the fill stays put.
    a_list_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsd_pkg::ST_LIST) |-> (remain_reg != '0) &&
        (remain_reg < count_reg) && $stable(count_reg))
        else $error("list sequence out of step with fill");

    // A result carrying an entry always has status ok.
    a_entry_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_entry) |-> (m_status == bsd_pkg::ST_OK))
        else $error("entry returned with failing status");

    // A result that is not the last of a list always carries an entry.
    a_more_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_has_entry && (state_reg == bsd_pkg::ST_LIST)))
        else $error("non-final result outside a list");

endmodule

`default_nettype wire

FILE: tb/deque_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque, keeps its own copy of the entries in a
// ring store, works out the results each accepted request must give, and
// compares every result transfer with the oldest result still awaited.
module deque_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [2:0]  s_req_type,
    input  wire  [63:0] s_text_low,
    input  wire  [55:0] s_text_high,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [1:0]  m_status,
    input  wire         m_has_entry,
    input  wire  [63:0] m_entry_low,
    input  wire  [55:0] m_entry_high,
    input  wire         m_last,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic        has_entry;
        logic [63:0] entry_low;
        logic [55:0] entry_high;
        logic        last;
    } deque_result_t;

    // Shadow copy of the deque.
    logic [119:0]  shadow_store [DEPTH];
    int unsigned   shadow_front;
    int unsigned   shadow_count;

    deque_result_t awaited_results [$];
    int            mismatches = 0;

    // Queues one result; the entry fields are zero unless an entry is carried.
    task automatic await_result(input logic [1:0] status, input logic has,
                                input logic [119:0] entry, input logic is_last);
        deque_result_t r;
        begin
            r.status     = status;
            r.has_entry  = has;
            r.entry_low  = has ? entry[63:0] : 64'd0;
            r.entry_high = has ? entry[119:64] : 56'd0;
            r.last       = is_last;
            awaited_results.push_back(r);
        end
    endtask

    // Applies one request to the shadow deque and queues the results it causes.
    task automatic predict_deque_request(input logic [2:0] req,
                                         input logic [63:0] lo,
                                         input logic [55:0] hi);
        int unsigned slot;
        int unsigned i;
        begin
            case (req)
                bsd_pkg::REQ_PUSH_FRONT, bsd_pkg::REQ_PUSH_REAR: begin
                    if (shadow_count >= DEPTH) begin
                        await_result(bsd_pkg::ST_FULL, 1'b0, '0, 1'b1);
                    end else begin
                        if (req == bsd_pkg::REQ_PUSH_FRONT) begin
                            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                            slot = shadow_front;
                        end else begin
                            slot = (shadow_front + shadow_count) % DEPTH;
                        end
                        shadow_store[slot] = {hi, lo};
                        shadow_count++;
                        await_result(bsd_pkg::ST_OK, 1'b0, '0, 1'b1);
                    end
                end
                bsd_pkg::REQ_POP_FRONT, bsd_pkg::REQ_POP_REAR: begin
                    if (shadow_count == 0) begin
                        await_result(bsd_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
                    end else begin
                        if (req == bsd_pkg::REQ_POP_FRONT) begin
                            slot = shadow_front;
                            shadow_front = (shadow_front + 1) % DEPTH;
                        end else begin
                            slot = (shadow_front + shadow_count - 1) % DEPTH;
                        end
                        shadow_count--;
                        await_result(bsd_pkg::ST_OK, 1'b1, shadow_store[slot], 1'b1);
                    end
                end
                bsd_pkg::REQ_LIST: begin
                    if (shadow_count == 0) begin
                        await_result(bsd_pkg::ST_EMPTY, 1'b0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < shadow_count; i++) begin
                            slot = (shadow_front + i) % DEPTH;
                            await_result(bsd_pkg::ST_OK, 1'b1, shadow_store[slot],
                                         i + 1 == shadow_count);
                        end
                    end
                end
                default: begin
                    await_result(bsd_pkg::ST_INVALID, 1'b0, '0, 1'b1);
                end
            endcase
        end
    endtask

    // Compares one field of a result transfer, widened to 64 bits.
    task automatic check_field(input string name, input logic [63:0] expected,
                               input logic [63:0] actual);
        begin
            if (actual !== expected) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, expected, actual);
            end
        end
    endtask

    // Requests are predicted before result transfers are compared, so the
    // order of the awaited results always follows the order of the requests.
    always @(posedge aclk) begin
        deque_result_t exp_r;
        if (!aresetn) begin
            shadow_front = 0;
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                predict_deque_request(s_req_type, s_text_low, s_text_high);
            end
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result transfer with none awaited: ",
                              "expected nothing, actual status %h entry %h_%h last %b"},
                             $time, m_status, m_entry_high, m_entry_low, m_last);
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("status", exp_r.status, m_status);
                    check_field("has_entry", exp_r.has_entry, m_has_entry);
                    check_field("entry_low", exp_r.entry_low, m_entry_low);
                    check_field("entry_high", exp_r.entry_high, m_entry_high);
                    check_field("last", exp_r.last, m_last);
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= awaited_results.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Drives requests into the deque with random gaps and random result stalls,
// and gives the verdict from the checker's counts.
module tb_top;

    localparam int unsigned DEPTH = 16;

    // Request codes that the block must refuse as invalid.
    localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [2:0]  s_req_type  = '0;
    logic [63:0] s_text_low  = '0;
    logic [55:0] s_text_high = '0;
    logic        m_ready     = 1'b0;
    logic        idle_on     = 1'b0;

    wire         s_ready;
    wire         m_valid;
    wire  [1:0]  m_status;
    wire         m_has_entry;
    wire  [63:0] m_entry_low;
    wire  [55:0] m_entry_high;
    wire         m_last;
    int          fail_count;
    int          pending_count;

    bounded_string_deque_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_text_low  (s_text_low),
        .s_text_high (s_text_high),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_has_entry (m_has_entry),
        .m_entry_low (m_entry_low),
        .m_entry_high(m_entry_high),
        .m_last      (m_last)
    );

    deque_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_text_low   (s_text_low),
        .s_text_high  (s_text_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_has_entry  (m_has_entry),
        .m_entry_low  (m_entry_low),
        .m_entry_high (m_entry_high),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // Clock with a 4 ns period.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Safety net against a hung block.
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // The receiver stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand_text_low();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [55:0] rand_text_high();
        logic [63:0] w;
        begin
            w = {$urandom, $urandom};
            return w[55:0];
        end
    endfunction

    // Draws a request; push_weight sets how strongly the deque tends to fill.
    function automatic logic [2:0] pick_request(input int push_weight);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < push_weight) begin
                return $urandom_range(0, 1) ? bsd_pkg::REQ_PUSH_FRONT :
                                              bsd_pkg::REQ_PUSH_REAR;
            end else if (r < 90) begin
                return $urandom_range(0, 1) ? bsd_pkg::REQ_POP_FRONT :
                                              bsd_pkg::REQ_POP_REAR;
            end else if (r < 96) begin
                return bsd_pkg::REQ_LIST;
            end else begin
                return 3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
            end
        end
    endfunction

    // Offers one request, possibly after a gap, and returns at its transfer.
    task automatic send_request(input logic [2:0] req, input logic [63:0] lo,
                                input logic [55:0] hi);
        begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            s_valid     <= 1'b1;
            s_req_type  <= req;
            s_text_low  <= lo;
            s_text_high <= hi;
            do begin
                @(posedge aclk);
            end while (s_ready !== 1'b1);
        end
    endtask

    // Holds the sender off until every awaited result has been transferred.
    task automatic wait_drained();
        begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (pending_count != 0) @(posedge aclk);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int i;
        int k;
        int push_weight;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on <= 1'b1;
        @(posedge aclk);

        // Directed: empty cases and invalid codes.
        send_request(bsd_pkg::REQ_LIST, rand_text_low(), rand_text_high());
        send_request(bsd_pkg::REQ_POP_FRONT, rand_text_low(), rand_text_high());
        send_request(bsd_pkg::REQ_POP_REAR, rand_text_low(), rand_text_high());
        send_request(REQ_RESERVED_LO, '1, '1);
        send_request(REQ_RESERVED_HI, '0, '0);

        // Directed: extreme texts, then fill to the brim and push beyond it.
        send_request(bsd_pkg::REQ_PUSH_FRONT, '1, '1);
        send_request(bsd_pkg::REQ_PUSH_REAR, '0, '0);
        send_request(bsd_pkg::REQ_LIST, '0, '0);
        for (i = 0; i < DEPTH - 2; i++) begin
            send_request((i % 2 == 0) ? bsd_pkg::REQ_PUSH_FRONT : bsd_pkg::REQ_PUSH_REAR,
                         rand_text_low(), rand_text_high());
        end
        send_request(bsd_pkg::REQ_PUSH_FRONT, rand_text_low(), rand_text_high());
        send_request(bsd_pkg::REQ_PUSH_REAR, rand_text_low(), rand_text_high());
        send_request(bsd_pkg::REQ_LIST, rand_text_low(), rand_text_high());
        wait_drained();

        // Random: chunks that lean towards filling or draining in turn;
        // the final chunk runs with no idling on either side.
        for (k = 0; k < 8; k++) begin
            push_weight = (k % 2 == 0) ? 70 : 25;
            if (k == 0) begin
                idle_on = 1'b1;
            end else if (k < 7) begin
                idle_on = 1'($urandom_range(0, 1));
            end else begin
                idle_on = 1'b0;
            end
            for (i = 0; i < 10; i++) begin
                send_request(pick_request(push_weight), rand_text_low(),
                             rand_text_high());
            end
            if (k == 3) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
